// File: hw/rtl/lubs_pkg.sv
// Shared types, widths and constants for the broken-stick / uniform sampler.
// Used by the generator, datapath, controller and top level; depends on nothing.
package lubs_pkg;

    // Field and datapath widths.
    localparam int STATE_W = 31;
    localparam int VAL_W   = 32;
    localparam int CV_W    = 16;
    localparam int LCG_M_W = 15;
    localparam int LPROD_W = STATE_W + LCG_M_W;
    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 32;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int ACC_W   = PROD_W + 1;
    localparam int T_W     = 33;

    // Generator constants.
    localparam logic [LCG_M_W-1:0] LCG_MUL    = LCG_M_W'(16807);
    localparam logic [STATE_W-1:0] LCG_MOD    = {STATE_W{1'b1}};
    localparam logic [STATE_W-1:0] HALF_POINT = STATE_W'(1) << (STATE_W - 1);

    // sqrt(3) in Q2.30.
    localparam logic signed [MUL_B_W-1:0] SQRT3_Q30 = MUL_B_W'(1859775393);

    // Rounding offsets loaded into the accumulator.
    localparam logic signed [ACC_W-1:0] RND_K  = ACC_W'(1) <<< 15;
    localparam logic signed [ACC_W-1:0] RND_E  = ACC_W'(1) <<< 28;
    localparam logic signed [ACC_W-1:0] RND_31 = ACC_W'(1) <<< 30;

    // Saturation bounds of a sample.
    localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(2147483647);
    localparam logic signed [ACC_W-1:0] SAT_MIN = -(ACC_W'(1) <<< 31);

    // Item commands.
    localparam logic [1:0] CMD_RESEED  = 2'd0;
    localparam logic [1:0] CMD_UNIFORM = 2'd1;
    localparam logic [1:0] CMD_STICK   = 2'd2;

    // Multiplier operand selections.
    localparam logic [2:0] MUL_CV_SQRT3 = 3'd0;
    localparam logic [2:0] MUL_K_D      = 3'd1;
    localparam logic [2:0] MUL_MEAN_E   = 3'd2;
    localparam logic [2:0] MUL_MEAN_X   = 3'd3;
    localparam logic [2:0] MUL_SUM_X    = 3'd4;
    localparam logic [2:0] MUL_Y_Z      = 3'd5;

    // Accumulator load selections.
    localparam logic [1:0] INIT_K     = 2'd0;
    localparam logic [1:0] INIT_E     = 2'd1;
    localparam logic [1:0] INIT_ROUND = 2'd2;
    localparam logic [1:0] INIT_MEAN  = 2'd3;

    typedef struct packed {
        logic [1:0]              command;
        logic signed [VAL_W-1:0] mean_value;
        logic [CV_W-1:0]         variation_coeff;
        logic signed [VAL_W-1:0] range_low;
        logic signed [VAL_W-1:0] range_high;
        logic [STATE_W-1:0]      seed_value;
    } lubs_in_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] sample_value;
        logic [STATE_W-1:0]      raw_draw;
    } lubs_out_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       capture;
        logic       seed_load;
        logic       lcg_mul;
        logic       lcg_fold;
        logic       prep;
        logic       mul_en;
        logic [2:0] mul_sel;
        logic       acc_load;
        logic [1:0] acc_init;
        logic       acc_add;
        logic [1:0] term_shift;
        logic       term_neg;
        logic       t_load_k;
        logic       t_load_e;
        logic       out_load;
        logic       out_zero;
    } lubs_cmd_t;

endpackage

// File: hw/rtl/lcg_uniform_broken_stick_sampler_core.sv
// Park-Miller uniform / broken-stick sampler, top level. Depends on lubs_pkg,
// lubs_ctrl, lubs_dp. Sample items step through START, FOLD, PREP, then KD, E, ME
// (uniform) or MX, SX, YZ (stick), then FIN, using the single shared 33x32 multiplier
// three times (uniform) or four (stick); reseed and unused commands go straight to FIN.
// Synchronous active-low reset sets the generator to one and empties the result register.
module lcg_uniform_broken_stick_sampler_core
    import lubs_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  lubs_in_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output lubs_out_t m_item
);

    lubs_cmd_t dp_cmd;

    lubs_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .in_command (s_item.command),
        .s_ready    (s_ready),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .cmd        (dp_cmd)
    );

    lubs_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (dp_cmd),
        .in_item  (s_item),
        .out_item (m_item)
    );

    // One item at a time: an accepted item closes the input until its result is written.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted again right after an item");

    // A result is written only while no item is being accepted.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !$past(s_ready))
        else $error("result appeared without an item in progress");

    // The generator never reaches zero or the modulus.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_item.raw_draw != '0) && (m_item.raw_draw != LCG_MOD))
        else $error("generator state left its legal range");

endmodule

// File: hw/rtl/lubs_lcg.sv
// Minimal-standard generator: state register, constant multiply and Mersenne fold.
// Depends on lubs_pkg.
module lubs_lcg
    import lubs_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               seed_load,
    input  logic [STATE_W-1:0] seed,
    input  logic               mul_en,
    input  logic               fold_en,
    output logic [STATE_W-1:0] state
);

    logic [STATE_W-1:0] state_reg, state_next;
    logic [LPROD_W-1:0] prod_reg;
    logic [LPROD_W-1:0] mul_p;
    logic [STATE_W:0]   fold_sum;
    logic [STATE_W:0]   fold_red;
    logic [STATE_W-1:0] fold_val;
    logic [STATE_W-1:0] seed_val;

    // Product of the state and 16807, registered before the fold.
    assign mul_p = state_reg * LCG_MUL;

    // x mod (2^31-1): add the high part to the low part, subtract once if needed.
    assign fold_sum = {1'b0, prod_reg[STATE_W-1:0]}
                    + (STATE_W + 1)'(prod_reg[LPROD_W-1:STATE_W]);
    assign fold_red = (fold_sum >= {1'b0, LCG_MOD}) ? fold_sum - {1'b0, LCG_MOD} : fold_sum;
    assign fold_val = (fold_red[STATE_W-1:0] == '0) ? STATE_W'(1) : fold_red[STATE_W-1:0];

    // A seed of zero or of the modulus would lock the generator; load one instead.
    assign seed_val = (seed == '0 || seed == LCG_MOD) ? STATE_W'(1) : seed;

    always_comb begin
        state_next = state_reg;
        if (seed_load) begin
            state_next = seed_val;
        end else if (fold_en) begin
            state_next = fold_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= STATE_W'(1);
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (mul_en) begin
            prod_reg <= mul_p;
        end
    end

    assign state = state_reg;

endmodule

// File: hw/rtl/lubs_dp.sv
// Sampler datapath: item registers, one shared signed multiplier, accumulator
// and output register. Depends on lubs_pkg and lubs_lcg.
module lubs_dp
    import lubs_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  lubs_cmd_t cmd,
    input  lubs_in_t  in_item,
    output lubs_out_t out_item
);

    logic [STATE_W-1:0]        gen_state;

    logic signed [VAL_W-1:0]   mean_reg;
    logic [CV_W-1:0]           cv_reg;
    logic signed [VAL_W-1:0]   low_reg;
    logic signed [VAL_W-1:0]   high_reg;
    logic signed [T_W-1:0]     lh_sum_reg;
    logic [STATE_W-1:0]        x_reg;
    logic [STATE_W-1:0]        z_reg;
    logic signed [STATE_W-1:0] d_reg;
    logic signed [VAL_W-1:0]   y_reg;
    logic signed [T_W-1:0]     t_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    lubs_out_t                 out_reg;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  mul_p;
    logic signed [ACC_W-1:0]   prod_ext;
    logic signed [ACC_W-1:0]   term;
    logic signed [ACC_W-1:0]   sum;
    logic signed [ACC_W-1:0]   quot;
    logic signed [ACC_W-1:0]   acc_init_val;
    logic signed [VAL_W-1:0]   sat_val;
    logic                      low_half;
    logic [STATE_W:0]          x_hi;
    logic [STATE_W-1:0]        d_raw;

    lubs_lcg u_lcg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .seed_load (cmd.seed_load),
        .seed      (in_item.seed_value),
        .mul_en    (cmd.lcg_mul),
        .fold_en   (cmd.lcg_fold),
        .state     (gen_state)
    );

    // Item capture; the bound sum is formed here so it never feeds the multiplier directly.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            mean_reg   <= in_item.mean_value;
            cv_reg     <= in_item.variation_coeff;
            low_reg    <= in_item.range_low;
            high_reg   <= in_item.range_high;
            lh_sum_reg <= T_W'($signed(in_item.range_low)) + T_W'($signed(in_item.range_high));
        end
    end

    // Operands that follow from the advanced state: the segment weights and 2u-1.
    assign low_half = (gen_state <= HALF_POINT);
    assign x_hi     = (STATE_W + 1)'(1) << STATE_W;
    assign d_raw    = gen_state - HALF_POINT;

    always_ff @(posedge aclk) begin
        if (cmd.prep) begin
            d_reg <= $signed(d_raw);
            if (low_half) begin
                x_reg <= gen_state;
                z_reg <= HALF_POINT - gen_state;
                y_reg <= low_reg;
            end else begin
                x_reg <= STATE_W'(x_hi - (STATE_W + 1)'(gen_state));
                z_reg <= gen_state - HALF_POINT;
                y_reg <= high_reg;
            end
        end
    end

    // Shared multiplier operand selection.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.mul_sel)
            MUL_CV_SQRT3: begin
                mul_a = $signed({{(MUL_A_W - CV_W){1'b0}}, cv_reg});
                mul_b = SQRT3_Q30;
            end
            MUL_K_D: begin
                mul_a = MUL_A_W'(d_reg);
                mul_b = $signed(t_reg[MUL_B_W-1:0]);
            end
            MUL_MEAN_E: begin
                mul_a = t_reg;
                mul_b = mean_reg;
            end
            MUL_MEAN_X: begin
                mul_a = $signed({{(MUL_A_W - STATE_W){1'b0}}, x_reg});
                mul_b = mean_reg;
            end
            MUL_SUM_X: begin
                mul_a = lh_sum_reg;
                mul_b = $signed({{(MUL_B_W - STATE_W){1'b0}}, x_reg});
            end
            MUL_Y_Z: begin
                mul_a = MUL_A_W'(y_reg);
                mul_b = $signed({{(MUL_B_W - STATE_W){1'b0}}, z_reg});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    always_ff @(posedge aclk) begin
        if (cmd.mul_en) begin
            prod_reg <= mul_p;
        end
    end

    // Accumulator term: the registered product, scaled by 1, 2 or 4 and optionally negated.
    assign prod_ext = ACC_W'(prod_reg);

    always_comb begin
        case (cmd.term_shift)
            2'd1:    term = prod_ext <<< 1;
            2'd2:    term = prod_ext <<< 2;
            default: term = prod_ext;
        endcase
        if (cmd.term_neg) begin
            term = -term;
        end
    end

    assign sum = acc_reg + term;

    // Accumulator start values: rounding offsets, or mean*2^31 plus the rounding half.
    always_comb begin
        case (cmd.acc_init)
            INIT_K:     acc_init_val = RND_K;
            INIT_E:     acc_init_val = RND_E;
            INIT_ROUND: acc_init_val = RND_31;
            default:    acc_init_val = (ACC_W'(mean_reg) <<< 31) + RND_31;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.acc_load) begin
            acc_reg <= acc_init_val;
        end else if (cmd.acc_add) begin
            acc_reg <= sum;
        end
    end

    // Scaled factor register: k = sqrt3*cv in Q0.30, then e = k*(2u-1) in Q1.31.
    always_ff @(posedge aclk) begin
        if (cmd.t_load_k) begin
            t_reg <= T_W'(sum >>> 16);
        end else if (cmd.t_load_e) begin
            t_reg <= T_W'(sum >>> 29);
        end
    end

    // Final scaling by 2^-31 and saturation to the sample width.
    assign quot = sum >>> 31;

    always_comb begin
        if (quot > SAT_MAX) begin
            sat_val = SAT_MAX[VAL_W-1:0];
        end else if (quot < SAT_MIN) begin
            sat_val = SAT_MIN[VAL_W-1:0];
        end else begin
            sat_val = quot[VAL_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_reg.sample_value <= cmd.out_zero ? '0 : sat_val;
            out_reg.raw_draw     <= gen_state;
        end
    end

    assign out_item = out_reg;

endmodule

// File: hw/rtl/lubs_ctrl.sv
// Sampler controller: handshakes and the state machine that sequences the datapath.
// Depends on lubs_pkg.
module lubs_ctrl
    import lubs_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic [1:0] in_command,
    output logic       s_ready,
    output logic       m_valid,
    input  logic       m_ready,
    output lubs_cmd_t  cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_START = 4'd1;
    localparam logic [3:0] S_FOLD  = 4'd2;
    localparam logic [3:0] S_PREP  = 4'd3;
    localparam logic [3:0] S_U_KD  = 4'd4;
    localparam logic [3:0] S_U_E   = 4'd5;
    localparam logic [3:0] S_U_ME  = 4'd6;
    localparam logic [3:0] S_B_MX  = 4'd7;
    localparam logic [3:0] S_B_SX  = 4'd8;
    localparam logic [3:0] S_B_YZ  = 4'd9;
    localparam logic [3:0] S_FIN   = 4'd10;

    logic [3:0] state_reg, state_next;
    logic       stick_reg, stick_next;
    logic       zero_reg, zero_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_free;

    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;
    assign out_free = !m_valid_reg || m_ready;

    // Next state and datapath commands.
    always_comb begin
        state_next = state_reg;
        stick_next = stick_reg;
        zero_next  = zero_reg;
        cmd        = '0;
        cmd.acc_init = INIT_K;
        cmd.mul_sel  = MUL_CV_SQRT3;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    unique case (in_command)
                        CMD_RESEED: begin
                            cmd.seed_load = 1'b1;
                            zero_next     = 1'b1;
                            state_next    = S_FIN;
                        end
                        CMD_UNIFORM: begin
                            stick_next = 1'b0;
                            zero_next  = 1'b0;
                            state_next = S_START;
                        end
                        CMD_STICK: begin
                            stick_next = 1'b1;
                            zero_next  = 1'b0;
                            state_next = S_START;
                        end
                        default: begin
                            zero_next  = 1'b1;
                            state_next = S_FIN;
                        end
                    endcase
                end
            end
            S_START: begin
                cmd.lcg_mul  = 1'b1;
                cmd.mul_en   = 1'b1;
                cmd.mul_sel  = MUL_CV_SQRT3;
                cmd.acc_load = 1'b1;
                cmd.acc_init = INIT_K;
                state_next   = S_FOLD;
            end
            S_FOLD: begin
                cmd.lcg_fold = 1'b1;
                cmd.t_load_k = 1'b1;
                cmd.acc_load = 1'b1;
                cmd.acc_init = stick_reg ? INIT_ROUND : INIT_E;
                state_next   = S_PREP;
            end
            S_PREP: begin
                cmd.prep   = 1'b1;
                state_next = stick_reg ? S_B_MX : S_U_KD;
            end
            S_U_KD: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_K_D;
                state_next  = S_U_E;
            end
            S_U_E: begin
                cmd.t_load_e = 1'b1;
                cmd.acc_load = 1'b1;
                cmd.acc_init = INIT_MEAN;
                state_next   = S_U_ME;
            end
            S_U_ME: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_MEAN_E;
                state_next  = S_FIN;
            end
            S_B_MX: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_MEAN_X;
                state_next  = S_B_SX;
            end
            S_B_SX: begin
                cmd.mul_en     = 1'b1;
                cmd.mul_sel    = MUL_SUM_X;
                cmd.acc_add    = 1'b1;
                cmd.term_shift = 2'd2;
                state_next     = S_B_YZ;
            end
            S_B_YZ: begin
                cmd.mul_en   = 1'b1;
                cmd.mul_sel  = MUL_Y_Z;
                cmd.acc_add  = 1'b1;
                cmd.term_neg = 1'b1;
                state_next   = S_FIN;
            end
            S_FIN: begin
                // The last product is folded in as the result is written.
                cmd.term_shift = stick_reg ? 2'd1 : 2'd0;
                cmd.out_zero   = zero_reg;
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // The result register stays full until the item is taken.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            stick_reg   <= 1'b0;
            zero_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            stick_reg   <= stick_next;
            zero_reg    <= zero_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule
